[rtl/conv2d_grouped_dilated_unit_assert.svh]
// Assertion macros used by the checker file.
`ifndef CONV2D_GROUPED_DILATED_UNIT_ASSERT_SVH
`define CONV2D_GROUPED_DILATED_UNIT_ASSERT_SVH
// Implication checked every clock outside reset.
`define CGD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CGD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/c2dgd_pkg.sv]
// Package: shared constants and types for the grouped dilated convolution unit.
package c2dgd_pkg;
  localparam int MAX_DIM_D = 32;
  localparam int MAX_CHANNELS_D = 16;
  localparam int MAX_KERNEL_D = 8;
  localparam logic [1:0] OP_ACT = 2'd0;
  localparam logic [1:0] OP_WGT = 2'd1;
  localparam logic [1:0] OP_BIAS = 2'd2;
  localparam logic [1:0] OP_PIX = 2'd3;
  localparam logic [2:0] REG_IN = 3'd0;
  localparam logic [2:0] REG_OUT = 3'd1;
  localparam logic [2:0] REG_CH = 3'd2;
  localparam logic [2:0] REG_GRP = 3'd3;
  localparam logic [2:0] REG_KER = 3'd4;
  localparam logic [2:0] REG_STR = 3'd5;
  localparam logic [2:0] REG_PAD = 3'd6;
  localparam logic [2:0] REG_DIL = 3'd7;
endpackage

[rtl/c2dgd_ram.sv]
// Generic single-port-write, one-port-read RAM with registered read data.
module c2dgd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/conv2d_grouped_dilated_unit.sv]
// Convolution unit: one output pixel per compute transfer, one shared multiply-accumulate.
// Load transfers (activation, weight, bias) write their memory in S_LOAD. A compute transfer
// first derives the per-group channel counts by repeated subtraction. Then, for each output
// channel, it walks every kernel tap: S_TAP and S_MAC for a tap outside the input, and S_TAP
// plus a memory read (S_RD) and a multiply-accumulate (S_MAC) per group input channel for a
// tap inside it, plus setup (S_CH), bias read (S_BRD, S_BWT), rounding (S_FIN) and output
// (S_OUT) per channel. Each result waits in the output register and the next channel starts
// only after it is taken.
module conv2d_grouped_dilated_unit #(
  parameter int MAX_DIM = c2dgd_pkg::MAX_DIM_D,
  parameter int MAX_CHANNELS = c2dgd_pkg::MAX_CHANNELS_D,
  parameter int MAX_KERNEL = c2dgd_pkg::MAX_KERNEL_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // op[1:0], addr[15:2], value[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result[15:0], channel[19:16], saturated[20], status[21]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  localparam int ACT_DEPTH = MAX_DIM * MAX_DIM * MAX_CHANNELS;
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int AAW = $clog2(ACT_DEPTH);
  localparam int WAW = $clog2(WGT_DEPTH);
  localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BDEPTH = 1 << BAW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_DIVI = 4'd2;
  localparam logic [3:0] S_DIVO = 4'd3;
  localparam logic [3:0] S_CH = 4'd4;
  localparam logic [3:0] S_TAP = 4'd5;
  localparam logic [3:0] S_RD = 4'd6;
  localparam logic [3:0] S_MAC = 4'd7;
  localparam logic [3:0] S_BRD = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;
  localparam logic [3:0] S_BWT = 4'd11;

  logic [9:0] in_shape, out_shape;
  logic [7:0] channel_counts;
  logic [4:0] group_count;
  logic [5:0] kernel_shape, stride_shape, pad_shape;
  logic [2:0] dilation_step;

  logic [3:0] state;
  logic [1:0] op;
  logic [13:0] addr;
  logic [15:0] value;
  logic [4:0] py, px;
  logic [4:0] groups;
  logic [4:0] icpg, ocpg, rem;
  logic [4:0] d, g, dcnt, c;
  logic [2:0] fh, fw;
  logic signed [9:0] iy, ix;
  logic signed [47:0] acc;
  logic signed [31:0] prod;
  logic err;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_shape <= 10'd1023; out_shape <= 10'd1023; channel_counts <= 8'd255;
      group_count <= 5'd1; kernel_shape <= 6'd18; stride_shape <= 6'd0;
      pad_shape <= 6'd0; dilation_step <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2dgd_pkg::REG_IN:  in_shape <= cfg_data;
        c2dgd_pkg::REG_OUT: out_shape <= cfg_data;
        c2dgd_pkg::REG_CH:  channel_counts <= cfg_data[7:0];
        c2dgd_pkg::REG_GRP: group_count <= cfg_data[4:0];
        c2dgd_pkg::REG_KER: kernel_shape <= cfg_data[5:0];
        c2dgd_pkg::REG_STR: stride_shape <= cfg_data[5:0];
        c2dgd_pkg::REG_PAD: pad_shape <= cfg_data[5:0];
        c2dgd_pkg::REG_DIL: dilation_step <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [4:0] n_ic, n_oc;
  assign n_ic = {1'b0, channel_counts[7:4]} + 5'd1;
  assign n_oc = {1'b0, channel_counts[3:0]} + 5'd1;

  // Tap and address arithmetic
  logic tap_ok, ic_ok, wgt_ok;
  logic [5:0] cin;
  logic [AAW-1:0] act_raddr;
  logic [WAW-1:0] wgt_raddr;
  logic [15:0] act_q, wgt_q, bias_q;
  logic [10:0] gic;
  assign gic = 11'(g) * 11'(icpg) + 11'(c);
  assign cin = gic[5:0];
  assign tap_ok = (iy >= 0) && (ix >= 0) && (iy <= $signed({5'd0, in_shape[9:5]}))
               && (ix <= $signed({5'd0, in_shape[4:0]})) && (iy < MAX_DIM) && (ix < MAX_DIM);
  assign ic_ok = (gic < 11'(MAX_CHANNELS));
  assign wgt_ok = (d < MAX_CHANNELS) && (fh < MAX_KERNEL) && (fw < MAX_KERNEL)
               && (c < MAX_CHANNELS);
  assign act_raddr = AAW'(((32'(iy) * MAX_DIM + 32'(ix)) * MAX_CHANNELS) + 32'(cin));
  assign wgt_raddr = WAW'(((32'(d) * MAX_KERNEL + 32'(fh)) * MAX_KERNEL + 32'(fw))
                          * MAX_CHANNELS + 32'(c));
  logic rd_ok;

  c2dgd_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act (
    .clk, .we(state == S_LOAD && op == c2dgd_pkg::OP_ACT && 32'(addr) < ACT_DEPTH),
    .waddr(AAW'(addr)), .wdata(value), .raddr(act_raddr), .rdata(act_q));
  c2dgd_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt (
    .clk, .we(state == S_LOAD && op == c2dgd_pkg::OP_WGT && 32'(addr) < WGT_DEPTH),
    .waddr(WAW'(addr)), .wdata(value), .raddr(wgt_raddr), .rdata(wgt_q));
  c2dgd_ram #(.WIDTH(16), .DEPTH(BDEPTH)) u_bias (
    .clk, .we(state == S_LOAD && op == c2dgd_pkg::OP_BIAS && 32'(addr) < MAX_CHANNELS),
    .waddr(BAW'(addr)), .wdata(value), .raddr(BAW'(d)), .rdata(bias_q));

  logic signed [47:0] biasx, rsum;
  assign biasx = (d < MAX_CHANNELS) ? 48'(signed'(bias_q)) : 48'sd0;
  assign rsum = biasx + (acc >>> 8);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          op <= s_tdata[1:0]; addr <= s_tdata[15:2]; value <= s_tdata[31:16];
          py <= s_tdata[11:7]; px <= s_tdata[6:2];
          groups <= (s_tdata[31:0] == 32'd0) ? 5'd1 : ((group_count == 5'd0) ? 5'd1 : group_count);
          if (s_tdata[1:0] == c2dgd_pkg::OP_PIX) begin
            if (s_tdata[15:12] != 4'd0 || s_tdata[11:7] > out_shape[9:5]
                || s_tdata[6:2] > out_shape[4:0]) begin
              m_tdata <= {2'b00, 1'b1, 1'b0, 4'd0, 16'd0};
              m_tlast <= 1'b1; m_tvalid <= 1'b1;
              state <= S_OUT; err <= 1'b1;
            end else begin
              err <= 1'b0;
              rem <= n_ic; icpg <= 5'd0; state <= S_DIVI;
            end
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: state <= S_IDLE;
        S_DIVI: if (rem >= groups) begin
          rem <= rem - groups; icpg <= icpg + 5'd1;
        end else begin
          rem <= n_oc; ocpg <= 5'd0; state <= S_DIVO;
        end
        S_DIVO: if (rem >= groups) begin
          rem <= rem - groups; ocpg <= ocpg + 5'd1;
        end else begin
          d <= 5'd0; g <= 5'd0; dcnt <= 5'd0; state <= S_CH;
        end
        S_CH: begin
          acc <= '0; fh <= 3'd0; fw <= 3'd0; c <= 5'd0;
          iy <= $signed({5'd0, py}) * $signed({6'd0, stride_shape[5:3]} + 10'sd1)
                - $signed({7'd0, pad_shape[5:3]});
          ix <= $signed({5'd0, px}) * $signed({6'd0, stride_shape[2:0]} + 10'sd1)
                - $signed({7'd0, pad_shape[2:0]});
          state <= (ocpg != 5'd0 && g < groups && icpg != 5'd0) ? S_TAP : S_BRD;
        end
        S_TAP: state <= (tap_ok) ? S_RD : S_MAC;
        S_RD: begin
          rd_ok <= tap_ok && ic_ok && wgt_ok;
          state <= S_MAC;
        end
        S_MAC: begin
          if (tap_ok) begin
            acc <= acc + (rd_ok ? 48'(prod) : 48'sd0);
          end
          if (tap_ok && c + 5'd1 < icpg) begin
            c <= c + 5'd1; state <= S_RD;
          end else begin
            c <= 5'd0;
            if (fw < kernel_shape[2:0]) begin
              fw <= fw + 3'd1; ix <= ix + 10'(dilation_step); state <= S_TAP;
            end else if (fh < kernel_shape[5:3]) begin
              fh <= fh + 3'd1; fw <= 3'd0; iy <= iy + 10'(dilation_step);
              ix <= ix - 10'(kernel_shape[2:0]) * 10'(dilation_step);
              state <= S_TAP;
            end else begin
              state <= S_BRD;
            end
          end
        end
        S_BRD: state <= S_BWT;
        S_BWT: state <= S_FIN;
        S_FIN: begin
          if (rsum > 48'sd32767) begin
            m_tdata <= {2'b00, 1'b0, 1'b1, d[3:0], 16'h7fff};
          end else if (rsum < -48'sd32768) begin
            m_tdata <= {2'b00, 1'b0, 1'b1, d[3:0], 16'h8000};
          end else begin
            m_tdata <= {2'b00, 1'b0, 1'b0, d[3:0], rsum[15:0]};
          end
          m_tlast <= (d + 5'd1 == n_oc);
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          if (err || d + 5'd1 == n_oc) begin
            state <= S_IDLE;
          end else begin
            d <= d + 5'd1;
            if (dcnt + 5'd1 == ocpg) begin
              dcnt <= 5'd0; g <= g + 5'd1;
            end else begin
              dcnt <= dcnt + 5'd1;
            end
            state <= S_CH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Product of the registered memory outputs, used by S_MAC in the cycle after S_RD.
  always_comb begin
    prod = signed'(wgt_q) * signed'(act_q);
  end
endmodule

[rtl/conv2d_grouped_dilated_unit_checker.sv]
// Port-level checker for the convolution unit, bound to the top level.
`include "conv2d_grouped_dilated_unit_assert.svh"
module conv2d_grouped_dilated_unit_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);
  `CGD_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `CGD_ASSERT_IMP(a_busy, clk, rst, m_tvalid, !s_tready)
  `CGD_ASSERT_IMP(a_err_last, clk, rst, m_tvalid && m_tdata[21], m_tlast && m_tdata[15:0] == 16'd0)
  `CGD_ASSERT_NXT(a_take, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule

bind conv2d_grouped_dilated_unit conv2d_grouped_dilated_unit_checker u_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast);
